// ===== design/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants and payload types for the symbol rewrite reachability block.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int unsigned SYM_W = 8;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned WORDS_PER_ROW = 4;
   localparam int unsigned WSEL_W = 2;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_RULE  = 2'd1,
      ACT_CHECK = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [SYM_W-1:0] from_symbol;
      logic [SYM_W-1:0] to_symbol;
      logic             from_present;
      logic             to_present;
      logic             final_position;
   } req_type;

   typedef struct packed {
      logic position_ok;
      logic verdict;
      logic is_last;
   } rsp_type;

endpackage

// ===== design/srr_stream_if.sv =====
// ----------------------------------------------------------------------------
// srr_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface srr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/srr_ram.sv =====
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read first port, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/symbol_rewrite_reachability.sv =====
// ----------------------------------------------------------------------------
// symbol_rewrite_reachability
// Graph reachability checker over byte symbols with adjacency in one RAM.
// ----------------------------------------------------------------------------
// a rule item does a read-modify-write of one adjacency word; a check item may wait on
//   a sweep that reads four adjacency words per expanded symbol on one port
// throughput: one item in flight; the next is taken after the result has left
// reset and each clear item run a clearing pass over all SYMBOL_COUNT*4 RAM words,
//   one RAM word a cycle, during which no item is accepted; verdict resets to one
// ----------------------------------------------------------------------------
module symbol_rewrite_reachability #(
   parameter int unsigned SYMBOL_COUNT = 256
) (
   input logic clock,
   input logic reset,
   srr_stream_if.sink   req,
   srr_stream_if.source rsp
);
   localparam int unsigned ROW_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int unsigned DEPTH = SYMBOL_COUNT * srr_pkg::WORDS_PER_ROW;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = ROW_W + 1;

   typedef enum logic [3:0] {
      ST_WIPE, ST_IDLE, ST_RULE_RD, ST_RULE_WAIT, ST_RULE_WR,
      ST_SEED_RD, ST_SEED_WAIT, ST_POP, ST_EXP_RD, ST_EXP_WAIT, ST_DONE,
      ST_EDGE_RD, ST_EDGE_WAIT, ST_EDGE_WR, ST_OUT
   } state_type;

   state_type                       state_ff;
   logic [ADDR_W-1:0]               wipe_ff;
   logic [srr_pkg::SYM_W-1:0]       src_ff, dst_ff;
   logic                            last_ff, ok_ff, verdict_ff;
   logic [srr_pkg::WSEL_W-1:0]      word_ff;
   logic [ROW_W-1:0]                row_ff;
   logic [SYMBOL_COUNT-1:0]         reached_ff, frontier_ff;
   logic [srr_pkg::WORD_W*srr_pkg::WORDS_PER_ROW-1:0] row_buf_ff;
   srr_pkg::rsp_type                rsp_ff;
   logic                            rsp_valid_ff;

   logic                            ram_we;
   logic [ADDR_W-1:0]               ram_addr;
   logic [srr_pkg::WORD_W-1:0]      ram_wdata, ram_rdata;
   logic [srr_pkg::WORD_W-1:0]      edge_bit;
   logic                            src_ok, dst_ok;
   logic [SYMBOL_COUNT-1:0]         fresh, row_bits, low_pick;
   logic [CNT_W-1:0]                pick;
   logic [srr_pkg::WORD_W*srr_pkg::WORDS_PER_ROW-1:0] row_next;

   srr_ram #(.WIDTH(srr_pkg::WORD_W), .DEPTH(DEPTH)) u_adj (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   assign src_ok = {1'b0, req.data.from_symbol} < CNT_W'(SYMBOL_COUNT) || CNT_W > 9;
   assign dst_ok = {1'b0, req.data.to_symbol} < CNT_W'(SYMBOL_COUNT) || CNT_W > 9;
   assign edge_bit = srr_pkg::WORD_W'(1) << dst_ff[5:0];

   // merge the just-read word into the row buffer
   always_comb begin
      row_next = row_buf_ff;
      row_next[word_ff*srr_pkg::WORD_W +: srr_pkg::WORD_W] = ram_rdata;
      row_bits = row_next[SYMBOL_COUNT-1:0];
      fresh = row_bits & ~reached_ff;
      low_pick = frontier_ff & (~frontier_ff + SYMBOL_COUNT'(1));
      pick = CNT_W'(SYMBOL_COUNT);
      for (int i = SYMBOL_COUNT - 1; i >= 0; i--) begin
         if (low_pick[i]) begin
            pick = CNT_W'(i);
         end
      end
   end

   // ram port control
   always_comb begin
      ram_we = 1'b0;
      ram_wdata = ram_rdata | edge_bit;
      ram_addr = {src_ff[ROW_W-1:0], dst_ff[7:6]};
      unique case (state_ff)
         ST_WIPE: begin
            ram_we = 1'b1;
            ram_wdata = '0;
            ram_addr = wipe_ff;
         end
         ST_RULE_WR, ST_EDGE_WR: ram_we = 1'b1;
         ST_SEED_RD: ram_addr = {src_ff[ROW_W-1:0], word_ff};
         ST_EXP_RD: ram_addr = {row_ff, word_ff};
         default: ram_addr = {src_ff[ROW_W-1:0], dst_ff[7:6]};
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // sequencer, verdict and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         wipe_ff <= '0;
         verdict_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_WIPE: begin
               wipe_ff <= wipe_ff + ADDR_W'(1);
               if (wipe_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  src_ff <= req.data.from_symbol;
                  dst_ff <= req.data.to_symbol;
                  last_ff <= req.data.final_position;
                  word_ff <= '0;
                  row_buf_ff <= '0;
                  unique case (srr_pkg::action_type'(req.data.action))
                     srr_pkg::ACT_CLEAR: begin
                        verdict_ff <= 1'b1;
                        wipe_ff <= '0;
                        state_ff <= ST_WIPE;
                     end
                     srr_pkg::ACT_RULE: begin
                        if (req.data.from_symbol != req.data.to_symbol
                            && src_ok && dst_ok) begin
                           state_ff <= ST_RULE_RD;
                        end
                     end
                     srr_pkg::ACT_CHECK: begin
                        if (!verdict_ff) begin
                           ok_ff <= 1'b0;
                           state_ff <= ST_OUT;
                        end else if (!req.data.from_present && !req.data.to_present) begin
                           ok_ff <= 1'b1;
                           state_ff <= ST_OUT;
                        end else if (req.data.from_present != req.data.to_present) begin
                           ok_ff <= 1'b0;
                           verdict_ff <= 1'b0;
                           state_ff <= ST_OUT;
                        end else if (req.data.from_symbol == req.data.to_symbol) begin
                           ok_ff <= 1'b1;
                           state_ff <= ST_OUT;
                        end else if (!src_ok || !dst_ok) begin
                           ok_ff <= 1'b0;
                           verdict_ff <= 1'b0;
                           state_ff <= ST_OUT;
                        end else begin
                           state_ff <= ST_SEED_RD;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_RULE_RD: state_ff <= ST_RULE_WAIT;
            ST_RULE_WAIT: state_ff <= ST_RULE_WR;
            ST_RULE_WR: state_ff <= ST_IDLE;
            // seed: read the four words of the source row
            ST_SEED_RD: state_ff <= ST_SEED_WAIT;
            ST_SEED_WAIT: begin
               row_buf_ff <= row_next;
               word_ff <= word_ff + srr_pkg::WSEL_W'(1);
               if (word_ff == srr_pkg::WSEL_W'(srr_pkg::WORDS_PER_ROW - 1)) begin
                  reached_ff <= row_bits;
                  frontier_ff <= row_bits;
                  state_ff <= ST_POP;
               end else begin
                  state_ff <= ST_SEED_RD;
               end
            end
            // take the lowest frontier symbol
            ST_POP: begin
               row_buf_ff <= '0;
               word_ff <= '0;
               if (frontier_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  row_ff <= pick[ROW_W-1:0];
                  frontier_ff <= frontier_ff & ~low_pick;
                  state_ff <= ST_EXP_RD;
               end
            end
            ST_EXP_RD: state_ff <= ST_EXP_WAIT;
            ST_EXP_WAIT: begin
               row_buf_ff <= row_next;
               word_ff <= word_ff + srr_pkg::WSEL_W'(1);
               if (word_ff == srr_pkg::WSEL_W'(srr_pkg::WORDS_PER_ROW - 1)) begin
                  reached_ff <= reached_ff | fresh;
                  frontier_ff <= frontier_ff | fresh;
                  state_ff <= ST_POP;
               end else begin
                  state_ff <= ST_EXP_RD;
               end
            end
            ST_DONE: begin
               ok_ff <= reached_ff[dst_ff[ROW_W-1:0]];
               if (reached_ff[dst_ff[ROW_W-1:0]]) begin
                  state_ff <= ST_EDGE_RD;
               end else begin
                  verdict_ff <= 1'b0;
                  state_ff <= ST_OUT;
               end
            end
            ST_EDGE_RD: state_ff <= ST_EDGE_WAIT;
            ST_EDGE_WAIT: state_ff <= ST_EDGE_WR;
            ST_EDGE_WR: state_ff <= ST_OUT;
            ST_OUT: begin
               rsp_ff.position_ok <= ok_ff;
               rsp_ff.verdict <= verdict_ff;
               rsp_ff.is_last <= last_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // a failing result never carries a true verdict after search
   a_fail_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.position_ok |-> !rsp.data.verdict)
      else $error("failed position with true verdict");
   // once false the verdict stays false until a clear item
   a_verdict_sticky: assert property (@(posedge clock) disable iff (reset)
      !verdict_ff && state_ff != ST_IDLE |=> !verdict_ff)
      else $error("verdict rose outside clear");
   // no item taken while the ram is being wiped
   a_no_accept_wipe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIPE |-> !req.ready)
      else $error("item accepted during clearing pass");
`endif
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for symbol_rewrite_reachability: builds rule graphs,
// checks string positions against a local reachability predictor, and
// randomizes sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned IDLE_LIMIT = 60000;
   localparam int unsigned DRAIN_CYCLES = 2000;
   localparam int unsigned ITEM_TARGET = 580;

   // predictor of the rule graph and case verdict, plus pending results
   class reach_scoreboard;
      bit [255:0]       adj_rows [256];
      bit               case_ok;
      srr_pkg::rsp_type pending [$];
      int               fail_count;

      function void wipe();
         foreach (adj_rows[i]) adj_rows[i] = '0;
         case_ok = 1'b1;
      endfunction

      // sweep over one or more edges from src
      function bit reaches(input logic [7:0] src, input logic [7:0] dst);
         bit [255:0] seen;
         bit [255:0] front;
         bit [255:0] fresh;
         int         v;
         seen  = adj_rows[src];
         front = seen;
         while (front != '0) begin
            v = 0;
            while (!front[v]) v++;
            front[v] = 1'b0;
            fresh = adj_rows[v] & ~seen;
            seen  |= fresh;
            front |= fresh;
         end
         return seen[dst];
      endfunction

      function void note_request(input srr_pkg::req_type r);
         srr_pkg::rsp_type e;
         bit               ok;
         case (srr_pkg::action_type'(r.action))
            srr_pkg::ACT_CLEAR: wipe();
            srr_pkg::ACT_RULE: begin
               if (r.from_symbol != r.to_symbol) adj_rows[r.from_symbol][r.to_symbol] = 1'b1;
            end
            srr_pkg::ACT_CHECK: begin
               ok = 1'b0;
               if (case_ok) begin
                  if (!r.from_present && !r.to_present) ok = 1'b1;
                  else if (r.from_present != r.to_present) ok = 1'b0;
                  else if (r.from_symbol == r.to_symbol) ok = 1'b1;
                  else begin
                     ok = reaches(r.from_symbol, r.to_symbol);
                     if (ok) adj_rows[r.from_symbol][r.to_symbol] = 1'b1;
                  end
                  if (!ok) case_ok = 1'b0;
               end
               e.position_ok = ok;
               e.verdict     = case_ok;
               e.is_last     = r.final_position;
               pending = {pending, e};
            end
            default: ;
         endcase
      endfunction

      function void check_result(input srr_pkg::rsp_type got);
         srr_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %b", $time, got);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         if (got.position_ok !== want.position_ok) begin
            $display("%0t: position_ok expected %b actual %b", $time, want.position_ok,
                     got.position_ok);
            fail_count++;
         end
         if (got.verdict !== want.verdict) begin
            $display("%0t: verdict expected %b actual %b", $time, want.verdict, got.verdict);
            fail_count++;
         end
         if (got.is_last !== want.is_last) begin
            $display("%0t: is_last expected %b actual %b", $time, want.is_last, got.is_last);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   srr_stream_if #(.payload_type(srr_pkg::req_type)) req_if ();
   srr_stream_if #(.payload_type(srr_pkg::rsp_type)) rsp_if ();

   symbol_rewrite_reachability u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   reach_scoreboard sb = new();
   int unsigned idle_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 1;

   always #5 clock = ~clock;

   // receiver stall pattern, its mode redrawn at random from four modes
   int unsigned stall_mode = 0;
   int unsigned stall_count = 0;
   always @(negedge clock) begin
      stall_count++;
      if (stall_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_if.ready = 1'b1;
         1: rsp_if.ready = 1'($urandom_range(0, 1));
         2: rsp_if.ready = ($urandom_range(0, 3) == 0);
         default: rsp_if.ready = (stall_count % 16) >= 5;
      endcase
   end

   // result sampling and idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // drive one item, waiting for acceptance; bursts with random gaps
   task automatic push(input srr_pkg::req_type r);
      int unsigned gap;
      req_if.data  = r;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 10);
         if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send(input srr_pkg::action_type act, input logic [7:0] src,
                       input logic [7:0] dst, input bit src_here = 1'b1,
                       input bit dst_here = 1'b1, input bit last = 1'b0);
      srr_pkg::req_type r;
      r.action         = act;
      r.from_symbol    = src;
      r.to_symbol      = dst;
      r.from_present   = src_here;
      r.to_present     = dst_here;
      r.final_position = last;
      push(r);
   endtask

   // one well-formed case over a small alphabet with random content
   task automatic random_case();
      int unsigned base;
      int unsigned span;
      int unsigned n_rules;
      int unsigned n_pos;
      bit          cut;
      base    = $urandom_range(0, 255 - 15);
      span    = $urandom_range(1, 15);
      n_rules = $urandom_range(0, 12);
      n_pos   = $urandom_range(1, 8);
      if ($urandom_range(0, 9) != 0)
         send(srr_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom));
      repeat (n_rules) send(srr_pkg::ACT_RULE, 8'(base + $urandom_range(0, span)),
                            8'(base + $urandom_range(0, span)), 1'($urandom), 1'($urandom),
                            1'($urandom));
      for (int p = 0; p < n_pos; p++) begin
         cut = ($urandom_range(0, 9) == 0);
         if (cut)
            send(srr_pkg::ACT_CHECK, 8'(base + $urandom_range(0, span)),
                 8'(base + $urandom_range(0, span)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p == n_pos - 1);
         else
            send(srr_pkg::ACT_CHECK, 8'(base + $urandom_range(0, span)),
                 8'(base + $urandom_range(0, span)), 1'b1, 1'b1, p == n_pos - 1);
      end
   endtask

   // long chain so the sweep walks deep
   task automatic chain_case();
      int unsigned len;
      len = $urandom_range(20, 40);
      send(srr_pkg::ACT_CLEAR, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < len; i++)
         send(srr_pkg::ACT_RULE, 8'(255 - i * 6), 8'(255 - (i + 1) * 6));
      send(srr_pkg::ACT_CHECK, 8'hff, 8'(255 - len * 6), 1'b1, 1'b1, 1'b0);
      send(srr_pkg::ACT_CHECK, 8'(255 - len * 6), 8'hff, 1'b1, 1'b1, 1'b1);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sb.wipe();

      // directed part
      send(srr_pkg::ACT_CHECK, 8'h00, 8'hff, 0, 0, 0);
      send(srr_pkg::ACT_CHECK, 8'h00, 8'h00, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'hff, 8'hff, 1, 1, 0);
      send(srr_pkg::ACT_RULE, 8'h07, 8'h07);
      send(srr_pkg::ACT_CHECK, 8'h07, 8'h08, 1, 1, 1);
      send(srr_pkg::ACT_CLEAR, 8'hff, 8'hff, 1, 1, 1);
      send(srr_pkg::ACT_RULE, 8'h00, 8'hff);
      send(srr_pkg::ACT_RULE, 8'hff, 8'h80);
      send(srr_pkg::ACT_NONE, 8'h80, 8'h00, 1, 1, 1);
      send(srr_pkg::ACT_CHECK, 8'h00, 8'h80, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'h00, 8'hff, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'h80, 8'h00, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'h00, 8'h80, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'h05, 8'h05, 1, 1, 1);
      send(srr_pkg::ACT_CLEAR, 8'h00, 8'h00);
      send(srr_pkg::ACT_CHECK, 8'h41, 8'h41, 1, 0, 1);
      send(srr_pkg::ACT_CLEAR, 8'h00, 8'h00);
      send(srr_pkg::ACT_CHECK, 8'h41, 8'h41, 0, 1, 1);
      send(srr_pkg::ACT_CLEAR, 8'h00, 8'h00);
      send(srr_pkg::ACT_RULE, 8'h03, 8'h04);
      send(srr_pkg::ACT_RULE, 8'h04, 8'h03);
      send(srr_pkg::ACT_CHECK, 8'h03, 8'h03, 1, 1, 0);
      send(srr_pkg::ACT_CHECK, 8'h04, 8'h03, 1, 1, 1);

      // random part: mostly well-formed cases, some noise
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0: chain_case();
            1, 2, 3: send(srr_pkg::action_type'($urandom_range(1, 3)), 8'($urandom),
                          8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            default: random_case();
         endcase
      end

      req_if.valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
